@@ rtl/core/fts_pkg.sv @@
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants of the five-table discrete sampler
// Table geometry, queue entry format and the xorshift step.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MAX_OUTCOMES   = 256;
    localparam int DIGIT_BITS     = 6;
    localparam int NUM_TABLES     = 5;
    localparam int PROB_BITS      = 30;
    localparam int VAL_BITS       = 9;
    localparam int OFFSET_BITS    = 8;
    localparam int ENTRY_CNT_BITS = $clog2(MAX_OUTCOMES + 1);
    localparam int RNG_BITS       = 32;
    localparam logic [RNG_BITS-1:0] RNG_SEED = 32'd182736531;

    // table depths and address widths
    localparam int DEPTH_A  = 64;
    localparam int DEPTH_B  = 4096;
    localparam int DEPTH_C  = 16384;
    localparam int ADDR_A   = $clog2(DEPTH_A);
    localparam int ADDR_B   = $clog2(DEPTH_B);
    localparam int ADDR_C   = $clog2(DEPTH_C);
    localparam int CNT_BITS = ADDR_C + 1;
    localparam logic [CNT_BITS-1:0] TABLE_DEPTH [NUM_TABLES] = '{
        CNT_BITS'(DEPTH_A), CNT_BITS'(DEPTH_B), CNT_BITS'(DEPTH_C),
        CNT_BITS'(DEPTH_C), CNT_BITS'(DEPTH_C)
    };

    // limits t1..t5 stay below 2^32
    localparam int LIMIT_BITS = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_BITS = 32;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 16;

    // tuser[0] codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef enum logic {
        QK_LOAD = 1'b0,
        QK_DRAW = 1'b1
    } qkind_t;

    // data: probability word for loads, 30-bit draw value j for draws
    typedef struct packed {
        qkind_t                kind;
        logic                  first;
        logic [VAL_BITS-1:0]   val;
        logic [PROB_BITS-1:0]  data;
    } qentry_t;

    function automatic logic [RNG_BITS-1:0] xorshift32(input logic [RNG_BITS-1:0] x);
        logic [RNG_BITS-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

@@ rtl/core/fts_front.sv @@
// ----------------------------------------------------------------------------
// fts_front: request intake and classification
// Advances the generator for draws, numbers outcomes for loads, drops loads
// past the outcome limit and pushes queue entries.
// ----------------------------------------------------------------------------
module fts_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fts_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic [fts_pkg::S_TUSER_BITS-1:0]  s_tuser,
    input  logic                              cfg_we,
    input  logic [fts_pkg::OFFSET_BITS-1:0]   cfg_wdata,
    input  logic                              q_full,
    output logic                              q_push,
    output fts_pkg::qentry_t                  q_entry
);

    logic [fts_pkg::RNG_BITS-1:0]       rng_reg, rng_next;
    logic [fts_pkg::ENTRY_CNT_BITS-1:0] entry_cnt_reg, entry_cnt_next;
    logic [fts_pkg::OFFSET_BITS-1:0]    offset_reg, offset_next;

    logic                               accept, is_draw, first, room;
    logic [fts_pkg::ENTRY_CNT_BITS-1:0] eff_cnt;
    logic [fts_pkg::RNG_BITS-1:0]       rng_step;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_draw  = (s_tuser[0] == fts_pkg::MODE_DRAW);
    assign first    = s_tuser[1];
    assign eff_cnt  = first ? '0 : entry_cnt_reg;
    assign room     = (eff_cnt < fts_pkg::ENTRY_CNT_BITS'(fts_pkg::MAX_OUTCOMES));
    assign rng_step = fts_pkg::xorshift32(rng_reg);
    assign q_push   = accept && (is_draw || room);

    always_comb begin
        q_entry.kind  = is_draw ? fts_pkg::QK_DRAW : fts_pkg::QK_LOAD;
        q_entry.first = first;
        q_entry.val   = fts_pkg::VAL_BITS'(eff_cnt) + fts_pkg::VAL_BITS'(offset_reg);
        q_entry.data  = is_draw ? rng_step[fts_pkg::RNG_BITS-1:2]
                                : s_tdata[fts_pkg::PROB_BITS-1:0];

        rng_next       = rng_reg;
        entry_cnt_next = entry_cnt_reg;
        offset_next    = cfg_we ? cfg_wdata : offset_reg;
        if (accept && is_draw) begin
            rng_next = rng_step;
        end
        if (accept && !is_draw && room) begin
            entry_cnt_next = eff_cnt + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg       <= fts_pkg::RNG_SEED;
            entry_cnt_reg <= '0;
            offset_reg    <= '0;
        end else begin
            rng_reg       <= rng_next;
            entry_cnt_reg <= entry_cnt_next;
            offset_reg    <= offset_next;
        end
    end

endmodule

@@ rtl/core/fts_queue.sv @@
// ----------------------------------------------------------------------------
// fts_queue: short request queue between front and back
// Small register FIFO; the head is shown while the queue is not empty.
// ----------------------------------------------------------------------------
module fts_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fts_pkg::qentry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output fts_pkg::qentry_t head
);

    fts_pkg::qentry_t                 slot_reg [fts_pkg::QUEUE_DEPTH];
    logic [fts_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [fts_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [fts_pkg::QPTR_BITS:0]      count_reg, count_next;

    assign full       = (count_reg == (fts_pkg::QPTR_BITS+1)'(fts_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/fts_back.sv @@
// ----------------------------------------------------------------------------
// fts_back: table fill sequencer and draw pipeline
// Loads append digit copies to the five tables one entry per table per
// cycle, then rebuild the limits. Draws run select, table read, output.
// ----------------------------------------------------------------------------
module fts_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  fts_pkg::qentry_t                  head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fts_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LIM1,
        ST_LIM2,
        ST_LIM3
    } state_t;

    typedef enum logic [2:0] {
        SEL_A,
        SEL_B,
        SEL_C,
        SEL_D,
        SEL_E,
        SEL_ZERO
    } sel_t;

    localparam int NT = fts_pkg::NUM_TABLES;
    localparam int LB = fts_pkg::LIMIT_BITS;
    localparam int DB = fts_pkg::DIGIT_BITS;
    localparam int PB = fts_pkg::PROB_BITS;
    localparam int VB = fts_pkg::VAL_BITS;
    localparam int CB = fts_pkg::CNT_BITS;

    // control and registered outputs
    state_t               state_reg, state_next;
    logic [DB-1:0]        step_reg, step_next;
    logic [CB-1:0]        cnt_reg [NT];
    logic [CB-1:0]        cnt_next [NT];
    logic [LB-1:0]        t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, cd_reg;
    logic [LB-1:0]        t1_next, t2_next, t3_next, t4_next, t5_next, cd_next;
    logic                 s1_v_reg, s1_v_next, s2_v_reg, s2_v_next;
    logic                 out_v_reg, out_v_next;
    logic [VB-1:0]        out_data_reg, out_data_next;

    // payload
    logic [DB-1:0]        digit_reg [NT];
    logic [DB-1:0]        digit_next [NT];
    logic [VB-1:0]        val_reg, val_next;
    sel_t                 s1_sel_reg, s1_sel_next, s2_sel_reg, s2_sel_next;
    logic [fts_pkg::ADDR_C-1:0] s1_idx_reg, s1_idx_next;

    // tables
    logic [VB-1:0] mem_a [fts_pkg::DEPTH_A];
    logic [VB-1:0] mem_b [fts_pkg::DEPTH_B];
    logic [VB-1:0] mem_c [fts_pkg::DEPTH_C];
    logic [VB-1:0] mem_d [fts_pkg::DEPTH_C];
    logic [VB-1:0] mem_e [fts_pkg::DEPTH_C];
    logic [VB-1:0] rd_a_reg, rd_b_reg, rd_c_reg, rd_d_reg, rd_e_reg;

    logic          advance, pop_draw, pop_load, load_done;
    logic [NT-1:0] wr_en;
    logic [LB:0]   jx, diff1, diff2, diff3, diff4, diff5;
    sel_t          sel_c;
    logic [fts_pkg::ADDR_C-1:0] idx_c;

    assign advance  = !out_v_reg || m_tready;
    assign pop_draw = (state_reg == ST_IDLE) && head_valid
                      && (head.kind == fts_pkg::QK_DRAW) && advance;
    assign pop_load = (state_reg == ST_IDLE) && head_valid
                      && (head.kind == fts_pkg::QK_LOAD) && !s1_v_reg;
    assign pop      = pop_draw || pop_load;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = fts_pkg::M_TDATA_BITS'(out_data_reg);

    // region select: sign of j - t_k tells j < t_k
    always_comb begin
        jx    = (LB+1)'(head.data);
        diff1 = jx - {1'b0, t1_reg};
        diff2 = jx - {1'b0, t2_reg};
        diff3 = jx - {1'b0, t3_reg};
        diff4 = jx - {1'b0, t4_reg};
        diff5 = jx - {1'b0, t5_reg};
        sel_c = SEL_ZERO;
        idx_c = '0;
        if (diff1[LB]) begin
            sel_c = SEL_A;
            idx_c = fts_pkg::ADDR_C'(head.data[PB-1 -: DB]);
        end else if (diff2[LB]) begin
            sel_c = SEL_B;
            idx_c = fts_pkg::ADDR_C'(diff1[PB-1 -: fts_pkg::ADDR_B]);
        end else if (diff3[LB]) begin
            sel_c = SEL_C;
            idx_c = diff2[PB-3*DB +: fts_pkg::ADDR_C];
        end else if (diff4[LB]) begin
            sel_c = SEL_D;
            idx_c = diff3[PB-4*DB +: fts_pkg::ADDR_C];
        end else if (diff5[LB]) begin
            sel_c = SEL_E;
            idx_c = diff4[fts_pkg::ADDR_C-1:0];
        end
    end

    always_comb begin
        load_done = 1'b1;
        for (int k = 0; k < NT; k++) begin
            wr_en[k] = (state_reg == ST_LOAD) && (step_reg < digit_reg[k])
                       && (cnt_reg[k] < fts_pkg::TABLE_DEPTH[k]);
            if (({1'b0, step_reg} + 1'b1) < {1'b0, digit_reg[k]}) begin
                load_done = 1'b0;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        t3_next       = t3_reg;
        t4_next       = t4_reg;
        t5_next       = t5_reg;
        cd_next       = cd_reg;
        val_next      = val_reg;
        s1_v_next     = s1_v_reg;
        s2_v_next     = s2_v_reg;
        out_v_next    = out_v_reg;
        out_data_next = out_data_reg;
        s1_sel_next   = s1_sel_reg;
        s1_idx_next   = s1_idx_reg;
        s2_sel_next   = s2_sel_reg;
        for (int k = 0; k < NT; k++) begin
            cnt_next[k]   = wr_en[k] ? cnt_reg[k] + 1'b1 : cnt_reg[k];
            digit_next[k] = digit_reg[k];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_load) begin
                    for (int k = 0; k < NT; k++) begin
                        digit_next[k] = head.data[PB-1-DB*k -: DB];
                        if (head.first) begin
                            cnt_next[k] = '0;
                        end
                    end
                    val_next   = head.val;
                    step_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step_next = step_reg + 1'b1;
                if (load_done) begin
                    state_next = ST_LIM1;
                end
            end
            ST_LIM1: begin
                t1_next    = LB'(cnt_reg[0]) << (PB - DB);
                t2_next    = (LB'(cnt_reg[0]) << (PB - DB))
                           + (LB'(cnt_reg[1]) << (PB - 2*DB));
                cd_next    = (LB'(cnt_reg[2]) << (PB - 3*DB))
                           + (LB'(cnt_reg[3]) << (PB - 4*DB));
                state_next = ST_LIM2;
            end
            ST_LIM2: begin
                t3_next    = t2_reg + (LB'(cnt_reg[2]) << (PB - 3*DB));
                t4_next    = t2_reg + cd_reg;
                state_next = ST_LIM3;
            end
            ST_LIM3: begin
                t5_next    = t4_reg + LB'(cnt_reg[4]);
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            s1_v_next   = pop_draw;
            s1_sel_next = sel_c;
            s1_idx_next = idx_c;
            s2_v_next   = s1_v_reg;
            s2_sel_next = s1_sel_reg;
            out_v_next  = s2_v_reg;
            case (s2_sel_reg)
                SEL_A:   out_data_next = rd_a_reg;
                SEL_B:   out_data_next = rd_b_reg;
                SEL_C:   out_data_next = rd_c_reg;
                SEL_D:   out_data_next = rd_d_reg;
                SEL_E:   out_data_next = rd_e_reg;
                default: out_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            t1_reg       <= '0;
            t2_reg       <= '0;
            t3_reg       <= '0;
            t4_reg       <= '0;
            t5_reg       <= '0;
            cd_reg       <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            out_data_reg <= '0;
            for (int k = 0; k < NT; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            t3_reg       <= t3_next;
            t4_reg       <= t4_next;
            t5_reg       <= t5_next;
            cd_reg       <= cd_next;
            s1_v_reg     <= s1_v_next;
            s2_v_reg     <= s2_v_next;
            out_v_reg    <= out_v_next;
            out_data_reg <= out_data_next;
            for (int k = 0; k < NT; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        s1_sel_reg <= s1_sel_next;
        s1_idx_reg <= s1_idx_next;
        s2_sel_reg <= s2_sel_next;
        for (int k = 0; k < NT; k++) begin
            digit_reg[k] <= digit_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en[0]) begin
            mem_a[cnt_reg[0][fts_pkg::ADDR_A-1:0]] <= val_reg;
        end
        if (advance) begin
            rd_a_reg <= mem_a[s1_idx_reg[fts_pkg::ADDR_A-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en[1]) begin
            mem_b[cnt_reg[1][fts_pkg::ADDR_B-1:0]] <= val_reg;
        end
        if (advance) begin
            rd_b_reg <= mem_b[s1_idx_reg[fts_pkg::ADDR_B-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en[2]) begin
            mem_c[cnt_reg[2][fts_pkg::ADDR_C-1:0]] <= val_reg;
        end
        if (advance) begin
            rd_c_reg <= mem_c[s1_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en[3]) begin
            mem_d[cnt_reg[3][fts_pkg::ADDR_C-1:0]] <= val_reg;
        end
        if (advance) begin
            rd_d_reg <= mem_d[s1_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en[4]) begin
            mem_e[cnt_reg[4][fts_pkg::ADDR_C-1:0]] <= val_reg;
        end
        if (advance) begin
            rd_e_reg <= mem_e[s1_idx_reg];
        end
    end

endmodule

@@ rtl/core/five_table_discrete_sampler.sv @@
// ----------------------------------------------------------------------------
// five_table_discrete_sampler: compact five-table discrete sampler
// Loads a distribution one 30-bit probability word per outcome, then draws
// outcomes with a 32-bit xorshift generator and five lookup tables.
// ----------------------------------------------------------------------------
// Draws: an accepted request passes the queue, then the select, table read
// and output registers before m_tvalid; draws sustain one request per cycle
// while m_tready is high and no load is in progress. Loads: the back end is
// busy for the one-entry-per-table-per-cycle fill and the limit rebuild.
// Reset: synchronous, active low; generator reseeded, counts and limits
// cleared. Table memories are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module five_table_discrete_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fts_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [29:0] prob_word, rest zero
    input  logic [fts_pkg::S_TUSER_BITS-1:0]  s_tuser,   // [0] mode, [1] first_entry
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fts_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [8:0] sample_value, rest zero
    // index_offset register
    input  logic                              cfg_we,
    input  logic [fts_pkg::OFFSET_BITS-1:0]   cfg_wdata
);

    // front -> queue -> back
    logic             q_push, q_full, q_pop, q_valid;
    fts_pkg::qentry_t q_entry, q_head;

    // Front: generator steps and outcome numbering happen at acceptance, so
    // the back end only sees ready-made j values and table values.
    fts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Queue lets requests keep arriving while the back end fills tables or
    // waits on m_tready.
    fts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Back: table fill sequencer plus select / read / output pipeline.
    fts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // queue writes come only from accepted requests
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && s_tready))
        else $error("queue push without accepted request");

    // reset empties the output stage
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

@@ verif/fts_sample_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fts_sample_checker: scoreboard for the five-table discrete sampler
// Watches the request, result and register ports, keeps its own copy of the
// generator, tables and fill counts, and compares every sample against the
// oldest predicted one. Hands a failure count and the number of samples
// still owed to the testbench top.
// ----------------------------------------------------------------------------
module fts_sample_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [fts_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [29:0] prob_word
    input  logic [fts_pkg::S_TUSER_BITS-1:0]  s_tuser,   // [0] mode, [1] first_entry
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [fts_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [8:0] sample_value
    input  logic                              cfg_we,
    input  logic [fts_pkg::OFFSET_BITS-1:0]   cfg_wdata,
    output int                                fail_count,
    output int                                pending
);
    import fts_pkg::*;

    logic [RNG_BITS-1:0]    xs_state;
    logic [VAL_BITS-1:0]    tab_mem [NUM_TABLES][DEPTH_C];
    int unsigned            tab_fill [NUM_TABLES];
    int unsigned            outcomes_seen;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [VAL_BITS-1:0]    sample_q [$];
    logic [VAL_BITS-1:0]    want;
    int                     bad_samples = 0;

    // split into base-64 digits, msd first; digit k appends copies to table k
    function automatic void store_prob_word(logic [PROB_BITS-1:0] p, logic first);
        int unsigned        digit;
        logic [VAL_BITS-1:0] tag;
        if (first) begin
            for (int k = 0; k < NUM_TABLES; k++) tab_fill[k] = 0;
            outcomes_seen = 0;
        end
        if (outcomes_seen >= MAX_OUTCOMES) return;
        tag = VAL_BITS'(outcomes_seen + 32'(offset_reg));
        for (int k = 0; k < NUM_TABLES; k++) begin
            digit = 32'((p >> (PROB_BITS - DIGIT_BITS * (k + 1))) & 30'h3F);
            // saturate at the table depth, extra copies dropped
            for (int n = 0; n < digit && tab_fill[k] < TABLE_DEPTH[k]; n++) begin
                tab_mem[k][tab_fill[k]] = tag;
                tab_fill[k]++;
            end
        end
        outcomes_seen++;
    endfunction

    // entries past the fill count read as zero
    function automatic logic [VAL_BITS-1:0] lookup(int k, longint unsigned idx);
        if (idx >= 64'(tab_fill[k])) return '0;
        return tab_mem[k][idx];
    endfunction

    function automatic logic [VAL_BITS-1:0] next_sample();
        logic [RNG_BITS-1:0] x;
        longint unsigned     j, t1, t2, t3, t4;
        x = xs_state;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        xs_state = x;
        j  = 64'(x >> 2);
        t1 = 64'(tab_fill[0]) << 24;
        t2 = t1 + (64'(tab_fill[1]) << 18);
        t3 = t2 + (64'(tab_fill[2]) << 12);
        t4 = t3 + (64'(tab_fill[3]) << 6);
        if (j < t1) return lookup(0, j >> 24);
        if (j < t2) return lookup(1, (j - t1) >> 18);
        if (j < t3) return lookup(2, (j - t2) >> 12);
        if (j < t4) return lookup(3, (j - t3) >> 6);
        return lookup(4, j - t4);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            xs_state = RNG_SEED;
            for (int k = 0; k < NUM_TABLES; k++) tab_fill[k] = 0;
            outcomes_seen = 0;
            offset_reg    = '0;
            sample_q.delete();
        end else begin
            // retire first: a sample leaving now belongs to an older draw
            if (m_tvalid && m_tready) begin
                if (sample_q.size() == 0) begin
                    $error("sample_value: got %0d with no sample pending",
                           m_tdata[VAL_BITS-1:0]);
                    bad_samples++;
                end else begin
                    want = sample_q.pop_front();
                    if (m_tdata[VAL_BITS-1:0] !== want) begin
                        $error("sample_value: expected %0d, got %0d",
                               want, m_tdata[VAL_BITS-1:0]);
                        bad_samples++;
                    end
                end
            end
            if (cfg_we) offset_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_DRAW) sample_q.push_back(next_sample());
                else store_prob_word(s_tdata[PROB_BITS-1:0], s_tuser[1]);
            end
        end
        fail_count <= bad_samples;
        pending    <= sample_q.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the five-table discrete sampler
// Directed loads and draws around the table limits, then random phases of
// distributions and draws under random source and sink stalls, with the
// index offset changed between phases. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import fts_pkg::*;

    localparam int ITEM_TARGET   = 1270;   // directed plus ~1250 random
    localparam int SETTLE_CYCLES = 400;    // settle time for a full queue of loads at the largest digit
    localparam logic [PROB_BITS-1:0] PROB_ONES = '1;
    localparam logic [PROB_BITS-1:0] PROB_HALF = 30'h2000_0000;
    localparam longint unsigned      PROB_UNIT = 64'h4000_0000;  // 2^30

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;     // [29:0] prob_word, rest zero
    logic [S_TUSER_BITS-1:0] s_tuser   = '0;     // [0] mode, [1] first_entry
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;            // [8:0] sample_value
    logic                    cfg_we    = 1'b0;
    logic [OFFSET_BITS-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    bit src_quiet  = 1'b0;   // phase with no source gaps

    always #5 aclk = ~aclk;

    five_table_discrete_sampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fts_sample_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // One request: optional gap with tvalid low, then hold until accepted.
    // Called at a clock edge; returns at the edge the request went in.
    task automatic send_request(logic mode, logic [PROB_BITS-1:0] prob, logic first);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(prob);
        s_tuser  <= {first, mode};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_load(logic [PROB_BITS-1:0] prob, logic first);
        send_request(MODE_LOAD, prob, first);
    endtask

    // draw requests carry random junk in the unused fields
    task automatic send_draw();
        send_request(MODE_DRAW, PROB_BITS'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Register writes only with the block idle: all samples back, then enough
    // cycles for trailing loads (which have no result) to finish their fill.
    task automatic write_offset(logic [OFFSET_BITS-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result sink: per sample a random hold-off, with occasional stretches
    // of back-to-back acceptance.
    initial begin
        int gap;
        int quiet_left;
        quiet_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (quiet_left > 0) begin
                gap = 0;
                quiet_left--;
            end else if ($urandom_range(0, 29) == 0) begin
                gap = 0;
                quiet_left = $urandom_range(20, 60);
            end else begin
                gap = $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // hard stop, several times the slowest legal run
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int                   n_out;
        int                   n_draw;
        int                   phase;
        int                   big_runs;
        int                   r;
        longint unsigned      left;
        longint unsigned      share;
        logic [PROB_BITS-1:0] p;
        bit                   noisy;
        bit                   broken;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // nothing loaded yet: every draw lands past the fill counts
        send_draw();
        send_request(MODE_DRAW, PROB_ONES, 1'b1);
        send_request(MODE_DRAW, '0, 1'b0);
        // all-ones words: 63 copies per table, table a saturates at 64
        send_load(PROB_ONES, 1'b1);
        send_load(PROB_ONES, 1'b0);
        send_load('0, 1'b0);
        repeat (4) send_draw();
        // two halves sum to exactly 2^30
        send_load(PROB_HALF, 1'b1);
        send_load(PROB_HALF, 1'b0);
        repeat (4) send_draw();
        // almost empty distribution, nearly every draw reads zero
        send_load(30'h1, 1'b1);
        repeat (3) send_draw();

        // ---- random phases ----
        phase    = 0;
        big_runs = 0;
        while (items_sent < ITEM_TARGET) begin
            // both offset extremes first, random ones after
            if (phase == 0)      write_offset('1);
            else if (phase == 1) write_offset('0);
            else                 write_offset(OFFSET_BITS'($urandom));
            src_quiet = ($urandom_range(0, 3) == 0);

            // outcome count: mostly small, sometimes past MAX_OUTCOMES
            r = $urandom_range(0, 99);
            if (r < 2 && big_runs < 2) begin
                n_out = MAX_OUTCOMES + $urandom_range(1, 4);
                big_runs++;
            end else if (r < 75) begin
                n_out = $urandom_range(1, 8);
            end else begin
                n_out = $urandom_range(9, 64);
            end
            noisy  = ($urandom_range(0, 99) < 15);   // words with no sum rule
            broken = ($urandom_range(0, 99) < 8);    // no first_entry: appends

            left = PROB_UNIT;
            for (int i = 0; i < n_out; i++) begin
                if (noisy) begin
                    p = PROB_BITS'($urandom);
                end else if (i == n_out - 1) begin
                    p = (left > 64'(PROB_ONES)) ? PROB_ONES : PROB_BITS'(left);
                end else begin
                    share = (left * 2) / 64'(n_out - i);
                    share = 64'($urandom_range(0, 32'(share)));
                    if (share > left) share = left;
                    if (share > 64'(PROB_ONES)) share = 64'(PROB_ONES);
                    p = PROB_BITS'(share);
                    left -= share;
                end
                send_load(p, (i == 0) && !broken);
            end

            // draws, with the odd stray load appended mid-stream
            n_draw = $urandom_range(10, 40);
            for (int i = 0; i < n_draw; i++) begin
                if ($urandom_range(0, 99) < 3) send_load(PROB_BITS'($urandom), 1'b0);
                else                           send_draw();
            end
            phase++;
        end

        // ---- drain ----
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
